### rtl/qrr_pkg.sv
// shared types and constants for the quadratic real roots block
// no dependencies
`timescale 1ns / 1ps

package qrr_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_WIDTH_DEF = 32;
   localparam int ROOT_FRAC      = 16;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_REAL = 2'd1,
      ST_A_ZERO  = 2'd2
   } status_type;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

### rtl/qrr_req_if.sv
// request channel: valid/ready handshake carrying the three coefficients
// depends on qrr_pkg
`timescale 1ns / 1ps

interface qrr_req_if import qrr_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

### rtl/qrr_rsp_if.sv
// response channel: valid/ready handshake carrying both roots and status
// depends on qrr_pkg
`timescale 1ns / 1ps

interface qrr_rsp_if import qrr_pkg::*; #(
   parameter int ROOT_WIDTH = ROOT_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [ROOT_WIDTH-1:0] root_plus;
   logic signed [ROOT_WIDTH-1:0] root_minus;
   status_type                   status;
   logic                         saturated;

   modport source (output valid, output root_plus, output root_minus, output status,
                   output saturated, input ready);
   modport sink (input valid, input root_plus, input root_minus, input status,
                 input saturated, output ready);
endinterface

### rtl/qrr_sqrt.sv
// pipelined floor integer square root, one result bit per stage
// depends on qrr_pkg
`timescale 1ns / 1ps

module qrr_sqrt import qrr_pkg::*; #(
   parameter int RAD_WIDTH = 36,
   parameter int SIDE_W    = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pipe_ctl_type             ctl,
   input  logic [RAD_WIDTH-1:0]     rad_in,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     valid_out,
   output logic [RAD_WIDTH/2-1:0]   root_out,
   output logic [SIDE_W-1:0]        side_out
);
   localparam int K = RAD_WIDTH / 2;

   logic [K:0]           rem_ff  [K];
   logic [K-1:0]         root_ff [K];
   logic [RAD_WIDTH-1:0] rad_ff  [K];
   logic [SIDE_W-1:0]    side_ff [K];
   logic [K-1:0]         v_ff;

   for (genvar gi = 0; gi < K; gi++) begin : g_stage
      logic [K:0]           rem_cur;
      logic [K-1:0]         root_cur;
      logic [RAD_WIDTH-1:0] rad_cur;
      logic [SIDE_W-1:0]    side_cur;
      logic                 v_cur;
      logic [K+2:0]         shifted;
      logic [K+2:0]         subtr;
      logic [K+2:0]         trial;
      logic                 fits;

      if (gi == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = rad_in;
         assign side_cur = side_in;
         assign v_cur    = ctl.valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[gi-1];
         assign root_cur = root_ff[gi-1];
         assign rad_cur  = rad_ff[gi-1];
         assign side_cur = side_ff[gi-1];
         assign v_cur    = v_ff[gi-1];
      end

      assign shifted = {rem_cur, rad_cur[RAD_WIDTH-1 -: 2]};
      assign subtr   = {1'b0, root_cur, 2'b01};
      assign fits    = shifted >= subtr;
      assign trial   = shifted - subtr;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[gi] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[gi] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_ff[gi]  <= fits ? trial[K:0] : shifted[K:0];
            root_ff[gi] <= {root_cur[K-2:0], fits};
            rad_ff[gi]  <= rad_cur << 2;
            side_ff[gi] <= side_cur;
         end
      end
   end

   assign valid_out = v_ff[K-1];
   assign root_out  = root_ff[K-1];
   assign side_out  = side_ff[K-1];

endmodule

### rtl/qrr_div.sv
// pipelined restoring divider, two dividends over one shared divisor,
// one quotient bit per stage; depends on qrr_pkg
`timescale 1ns / 1ps

module qrr_div import qrr_pkg::*; #(
   parameter int NW     = 34,
   parameter int DW     = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  pipe_ctl_type      ctl,
   input  logic [NW-1:0]     dvd_p_in,
   input  logic [NW-1:0]     dvd_m_in,
   input  logic [DW-1:0]     den_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [NW-1:0]     quot_p_out,
   output logic [NW-1:0]     quot_m_out,
   output logic [SIDE_W-1:0] side_out
);
   logic [DW-1:0]     rem_p_ff [NW];
   logic [DW-1:0]     rem_m_ff [NW];
   logic [NW-1:0]     dvd_p_ff [NW];
   logic [NW-1:0]     dvd_m_ff [NW];
   logic [NW-1:0]     q_p_ff   [NW];
   logic [NW-1:0]     q_m_ff   [NW];
   logic [DW-1:0]     den_ff   [NW];
   logic [SIDE_W-1:0] side_ff  [NW];
   logic [NW-1:0]     v_ff;

   for (genvar gi = 0; gi < NW; gi++) begin : g_stage
      logic [DW-1:0]     rem_p_cur, rem_m_cur, den_cur;
      logic [NW-1:0]     dvd_p_cur, dvd_m_cur, q_p_cur, q_m_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              v_cur;
      logic [DW:0]       t_p, t_m, d_p, d_m;
      logic              fit_p, fit_m;

      if (gi == 0) begin : g_first
         assign rem_p_cur = '0;
         assign rem_m_cur = '0;
         assign dvd_p_cur = dvd_p_in;
         assign dvd_m_cur = dvd_m_in;
         assign q_p_cur   = '0;
         assign q_m_cur   = '0;
         assign den_cur   = den_in;
         assign side_cur  = side_in;
         assign v_cur     = ctl.valid;
      end else begin : g_next
         assign rem_p_cur = rem_p_ff[gi-1];
         assign rem_m_cur = rem_m_ff[gi-1];
         assign dvd_p_cur = dvd_p_ff[gi-1];
         assign dvd_m_cur = dvd_m_ff[gi-1];
         assign q_p_cur   = q_p_ff[gi-1];
         assign q_m_cur   = q_m_ff[gi-1];
         assign den_cur   = den_ff[gi-1];
         assign side_cur  = side_ff[gi-1];
         assign v_cur     = v_ff[gi-1];
      end

      assign t_p   = {rem_p_cur, dvd_p_cur[NW-1]};
      assign t_m   = {rem_m_cur, dvd_m_cur[NW-1]};
      assign fit_p = t_p >= {1'b0, den_cur};
      assign fit_m = t_m >= {1'b0, den_cur};
      assign d_p   = t_p - {1'b0, den_cur};
      assign d_m   = t_m - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[gi] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[gi] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_p_ff[gi] <= fit_p ? d_p[DW-1:0] : t_p[DW-1:0];
            rem_m_ff[gi] <= fit_m ? d_m[DW-1:0] : t_m[DW-1:0];
            dvd_p_ff[gi] <= dvd_p_cur << 1;
            dvd_m_ff[gi] <= dvd_m_cur << 1;
            q_p_ff[gi]   <= {q_p_cur[NW-2:0], fit_p};
            q_m_ff[gi]   <= {q_m_cur[NW-2:0], fit_m};
            den_ff[gi]   <= den_cur;
            side_ff[gi]  <= side_cur;
         end
      end
   end

   assign valid_out  = v_ff[NW-1];
   assign quot_p_out = q_p_ff[NW-1];
   assign quot_m_out = q_m_ff[NW-1];
   assign side_out   = side_ff[NW-1];

endmodule

### rtl/quadratic_real_roots.sv
// top level: real roots of a*x^2 + b*x + c in fixed point
// depends on qrr_pkg, qrr_req_if, qrr_rsp_if, qrr_sqrt, qrr_div
//
//   channel   direction  payload
//   req_chan  in         coef_a, coef_b, coef_c (signed Q8.8)
//   rsp_chan  out        root_plus, root_minus (signed Q16.16), status, saturated
//
// one transaction per cycle while rsp_chan is not stalled; the square root and
// divider pipes each resolve one bit per stage
// synchronous reset clears all valid bits; no clearing pass
// a stall on rsp_chan freezes the whole pipeline and req_chan.ready drops with it
`timescale 1ns / 1ps

module quadratic_real_roots import qrr_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int ROOT_WIDTH = ROOT_WIDTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   qrr_req_if.sink   req_chan,
   qrr_rsp_if.source rsp_chan
);
   localparam int W     = COEF_WIDTH;
   localparam int R     = ROOT_WIDTH;
   localparam int DSW   = 2 * W + 2;
   localparam int K     = W + 1;
   localparam int NUMW  = W + 3;
   localparam int MAGW  = W + 2;
   localparam int NW    = MAGW + ROOT_FRAC;
   localparam int DENW  = W + 1;
   localparam int XW    = ((NW > R) ? NW : R) + 1;
   localparam int SSIDE = 2 + 2 * W;

   typedef struct packed {
      logic [R-1:0] value;
      logic         sat;
   } root_res_type;

   function automatic root_res_type clip_root(input logic [NW-1:0] q, input logic neg);
      logic [XW-1:0] q_x;
      logic [XW-1:0] lim;
      logic [XW-1:0] q_neg;
      root_res_type  res;
      q_x   = XW'(q);
      lim   = XW'(1) << (R - 1);
      q_neg = -q_x;
      if (neg && (q != '0)) begin
         res.sat   = q_x > lim;
         res.value = res.sat ? lim[R-1:0] : q_neg[R-1:0];
      end else begin
         res.sat   = q_x >= lim;
         res.value = res.sat ? ~lim[R-1:0] : q_x[R-1:0];
      end
      return res;
   endfunction

   logic         en;
   pipe_ctl_type ctl1, ctl3;

   // stage 1: products
   logic                  v1_ff;
   logic signed [W-1:0]   a1_ff, b1_ff;
   logic signed [2*W-1:0] bb_ff, ac_ff, bb_in, ac_in;

   // stage 2: discriminant and status
   logic                  v2_ff;
   logic signed [W-1:0]   a2_ff, b2_ff;
   logic [DSW-1:0]        disc_ff;
   status_type            st2_ff;
   logic signed [DSW-1:0] disc_in;
   status_type            st2_in;

   // square root pipe
   logic             sq_v;
   logic [K-1:0]     sq_root;
   logic [SSIDE-1:0] sq_side;
   status_type       sq_st;
   logic signed [W-1:0] sq_a, sq_b;

   // stage 3: numerators and divisor
   logic signed [NUMW-1:0] b_x, s_x, num_p, num_m, abs_p, abs_m;
   logic signed [DENW-1:0] a_x, a_abs;
   logic                   v3_ff, neg_p_ff, neg_m_ff;
   logic [NW-1:0]          dvd_p_ff, dvd_m_ff;
   logic [DENW-1:0]        den_ff;
   status_type             st3_ff;

   // divider pipe
   logic          dv_v;
   logic [NW-1:0] q_p, q_m;
   logic [3:0]    dv_side;
   status_type    dv_st;
   root_res_type  res_p, res_m;

   // output register
   logic                rsp_valid_ff;
   logic [R-1:0]        rp_ff, rm_ff;
   status_type          st_ff;
   logic                sat_ff;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   assign bb_in = req_chan.coef_b * req_chan.coef_b;
   assign ac_in = req_chan.coef_a * req_chan.coef_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= req_chan.coef_a;
         b1_ff <= req_chan.coef_b;
         bb_ff <= bb_in;
         ac_ff <= ac_in;
      end
   end

   assign disc_in = DSW'(bb_ff) - (DSW'(ac_ff) <<< 2);

   always_comb begin
      if (a1_ff == '0) begin
         st2_in = ST_A_ZERO;
      end else if (disc_in < 0) begin
         st2_in = ST_NO_REAL;
      end else begin
         st2_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         st2_ff  <= st2_in;
         disc_ff <= (st2_in == ST_OK) ? disc_in : '0;
      end
   end

   assign ctl1.en    = en;
   assign ctl1.valid = v2_ff;

   qrr_sqrt #(
      .RAD_WIDTH (DSW),
      .SIDE_W    (SSIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl1),
      .rad_in    (disc_ff),
      .side_in   ({st2_ff, a2_ff, b2_ff}),
      .valid_out (sq_v),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   assign sq_st = status_type'(sq_side[SSIDE-1 -: 2]);
   assign sq_a  = sq_side[2*W-1:W];
   assign sq_b  = sq_side[W-1:0];

   assign b_x   = NUMW'(sq_b);
   assign s_x   = NUMW'(sq_root);
   assign num_p = s_x - b_x;
   assign num_m = -(s_x + b_x);
   assign abs_p = num_p[NUMW-1] ? -num_p : num_p;
   assign abs_m = num_m[NUMW-1] ? -num_m : num_m;
   assign a_x   = DENW'(sq_a);
   assign a_abs = a_x[DENW-1] ? -a_x : a_x;

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_p_ff <= {abs_p[MAGW-1:0], {ROOT_FRAC{1'b0}}};
         dvd_m_ff <= {abs_m[MAGW-1:0], {ROOT_FRAC{1'b0}}};
         den_ff   <= {a_abs[W-1:0], 1'b0};
         neg_p_ff <= num_p[NUMW-1] ^ sq_a[W-1];
         neg_m_ff <= num_m[NUMW-1] ^ sq_a[W-1];
         st3_ff   <= sq_st;
      end
   end

   assign ctl3.en    = en;
   assign ctl3.valid = v3_ff;

   qrr_div #(
      .NW     (NW),
      .DW     (DENW),
      .SIDE_W (4)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl3),
      .dvd_p_in   (dvd_p_ff),
      .dvd_m_in   (dvd_m_ff),
      .den_in     (den_ff),
      .side_in    ({st3_ff, neg_p_ff, neg_m_ff}),
      .valid_out  (dv_v),
      .quot_p_out (q_p),
      .quot_m_out (q_m),
      .side_out   (dv_side)
   );

   assign dv_st = status_type'(dv_side[3:2]);
   assign res_p = clip_root(q_p, dv_side[1]);
   assign res_m = clip_root(q_m, dv_side[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= dv_st;
         if (dv_st == ST_OK) begin
            rp_ff  <= res_p.value;
            rm_ff  <= res_m.value;
            sat_ff <= res_p.sat || res_m.sat;
         end else begin
            rp_ff  <= '0;
            rm_ff  <= '0;
            sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.root_plus  = rp_ff;
   assign rsp_chan.root_minus = rm_ff;
   assign rsp_chan.status     = st_ff;
   assign rsp_chan.saturated  = sat_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (st_ff != ST_OK) |-> (rp_ff == '0) && (rm_ff == '0) && !sat_ff)
      else $error("nonzero status with nonzero roots");

   a_sat_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sat_ff |-> st_ff == ST_OK)
      else $error("saturation flagged on an error transaction");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v3_ff) && $stable(dvd_p_ff))
      else $error("pipeline moved during a stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid straight after reset");
`endif

endmodule

### tb/qrr_checker.sv
// checker for the quadratic real roots block: watches both channels, predicts and compares
// depends on qrr_pkg, qrr_req_if, qrr_rsp_if
`timescale 1ns / 1ps

module qrr_checker import qrr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qrr_req_if.sink   req_mon,
   qrr_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_roots
);

   typedef struct {
      logic signed [31:0] root_plus;
      logic signed [31:0] root_minus;
      status_type         status;
      logic               saturated;
   } roots_type;

   roots_type expected_roots[$];

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] scaled_quotient(longint num, longint a,
                                                          inout logic sat);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned q;
      logic neg;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      den = ((a < 0) ? longint'(-a) : longint'(a)) * 2;
      q = (mag << ROOT_FRAC) / den;
      neg = ((num < 0) != (a < 0)) && q != 0;
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
         end
         return 32'(-longint'(q));
      end
      if (q > 64'h7fff_ffff) begin
         sat = 1'b1;
         return 32'sh7fff_ffff;
      end
      return 32'(q);
   endfunction

   function automatic roots_type solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                             logic signed [15:0] cc);
      roots_type r;
      longint a;
      longint b;
      longint c;
      longint disc;
      longint s;
      logic sat;
      a = ca;
      b = cb;
      c = cc;
      sat = 1'b0;
      r.root_plus = '0;
      r.root_minus = '0;
      r.status = ST_OK;
      if (a == 0) begin
         r.status = ST_A_ZERO;
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            r.status = ST_NO_REAL;
         end else begin
            s = longint'(floor_sqrt(disc));
            r.root_plus = scaled_quotient(-b + s, a, sat);
            r.root_minus = scaled_quotient(-b - s, a, sat);
         end
      end
      r.saturated = sat;
      return r;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      roots_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_roots.push_back(solve_roots(req_mon.coef_a, req_mon.coef_b,
                                                 req_mon.coef_c));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_roots.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transaction");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (want.root_plus !== rsp_mon.root_plus || want.root_minus !== rsp_mon.root_minus
                   || want.status !== rsp_mon.status || want.saturated !== rsp_mon.saturated) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want.root_plus, want.root_minus, want.status, want.saturated,
                              rsp_mon.root_plus, rsp_mon.root_minus, rsp_mon.status,
                              rsp_mon.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### tb/tb.sv
// testbench top: clock, reset, coefficient stimulus, result back-pressure and verdict
// depends on qrr_pkg, qrr_req_if, qrr_rsp_if, quadratic_real_roots, qrr_checker
`timescale 1ns / 1ps

module tb;
   import qrr_pkg::*;

   localparam int LATENCY = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_roots;
   int   idle_cycles;
   logic stim_done;
   logic long_hold;

   qrr_req_if req_chan ();
   qrr_rsp_if rsp_chan ();

   quadratic_real_roots dut (.clock(clock), .reset(reset), .req_chan(req_chan),
                             .rsp_chan(rsp_chan));
   qrr_checker watcher (.clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
                        .fail_count(fail_count), .pending_roots(pending_roots));

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         4: return 16'(int'($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.coef_a <= a;
      req_chan.coef_b <= b;
      req_chan.coef_c <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   initial begin
      logic [15:0] ext[5];
      ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
      req_chan.valid  = 1'b0;
      req_chan.coef_a = '0;
      req_chan.coef_b = '0;
      req_chan.coef_c = '0;
      stim_done = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero a, negative discriminant, real roots, saturation
      send_coefs(16'h0000, 16'h0100, 16'h0100);
      send_coefs(16'h0000, 16'h8000, 16'h7fff);
      send_coefs(16'h0100, 16'h0000, 16'h0100);
      send_coefs(16'h0100, 16'h0000, 16'hff00);
      send_coefs(16'h0100, 16'hfe00, 16'h0100);
      send_coefs(16'h0001, 16'h7fff, 16'h0000);
      send_coefs(16'h0001, 16'h8000, 16'h8000);
      send_coefs(16'hffff, 16'h8000, 16'h7fff);
      for (int i = 0; i < 16; i++)
         send_coefs(ext[$urandom_range(0, 4)], ext[i % 5], ext[(i * 3) % 5]);
      for (int i = 0; i < 1550; i++) begin
         send_coefs(pick_coef(), pick_coef(), pick_coef());
         if (i == 700) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending_roots != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      stim_done <= 1'b1;
   end

   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      long_hold = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            hold = $urandom_range(0, 7);
            if (!long_hold && pending_roots > 20) begin
               long_hold = 1'b1;
               hold = 200;
            end
            if (hold != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      @(posedge stim_done);
      while (pending_roots != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0 && pending_roots == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
